// ----- rtl/jsce_pkg.sv -----
// Package for the JTAG scan command encoder.
// Holds the command codes, the queue descriptor type and the bit-bang helper.
// It has no dependencies. Every other file of the block but jsce_out_if imports it.
package jsce_pkg;

  localparam int LenBits   = 16;
  localparam int MaxChunk  = 32;
  localparam int ChunkBits = 6;
  localparam int QDepth    = 2;
  localparam int QPtrBits  = 1;

  localparam logic [7:0] CmdBase  = 8'h2C;
  localparam logic [7:0] CmdTck   = 8'h01;
  localparam logic [7:0] CmdTms   = 8'h02;
  localparam logic [7:0] CmdTdi   = 8'h10;
  localparam logic [7:0] CmdRead  = 8'h40;
  localparam logic [7:0] HdrShift = 8'h80;

  typedef enum logic [1:0] {
    DESC_BYTE = 2'd0,
    DESC_TMS  = 2'd1,
    DESC_TAIL = 2'd2
  } desc_kind_e;

  // One queued item, already classified. The back end only expands it.
  typedef struct packed {
    desc_kind_e  kind;
    logic [7:0]  data;
    logic        hdr_en;
    logic [7:0]  hdr;
    logic [3:0]  npairs;
    logic [1:0]  extra;
    logic        xbit;
    logic        rd;
    logic [4:0]  n_total;
    logic        last_req;
  } desc_t;

  function automatic logic [7:0] bang(input logic tms, input logic tdi,
                                      input logic tck, input logic rd);
    return CmdBase | (tck ? CmdTck : 8'h00) | (tms ? CmdTms : 8'h00) |
           (tdi ? CmdTdi : 8'h00) | (rd ? CmdRead : 8'h00);
  endfunction

endpackage

// ----- rtl/jsce_in_if.sv -----
// Request channel of the JTAG scan command encoder: one data byte per item.
// Depends on jsce_pkg for the length width.
interface jsce_in_if;
  import jsce_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         data_byte;
  logic               first_byte;
  logic [LenBits-1:0] total_bits;
  logic               exit_shift;
  logic               capture;

  modport source (output valid, req_type, data_byte, first_byte, total_bits,
                  exit_shift, capture, input ready);
  modport sink   (input valid, req_type, data_byte, first_byte, total_bits,
                  exit_shift, capture, output ready);
endinterface

// ----- rtl/jsce_out_if.sv -----
// Command channel of the JTAG scan command encoder: one command byte per item.
// No dependencies.
interface jsce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_byte;
  logic       last_of_item;
  logic       last_of_request;

  modport source (output valid, command_byte, last_of_item, last_of_request,
                  input ready);
  modport sink   (input valid, command_byte, last_of_item, last_of_request,
                  output ready);
endinterface

// ----- rtl/jsce_front.sv -----
// Front end: accepts request bytes, tracks the request and classifies each byte.
// Depends on jsce_pkg and jsce_in_if.
module jsce_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  jsce_in_if.sink        req_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output jsce_pkg::desc_t q_desc_o
);
  import jsce_pkg::*;

  logic [LenBits-1:0]   bits_done_q, bits_done_d;
  logic [LenBits-1:0]   req_len_q, req_len_d;
  logic [ChunkBits-1:0] chunk_left_q, chunk_left_d;
  logic [2:0]           flags_q, flags_d;

  logic [LenBits-1:0]   done_e, len_e, end_v, span_w, bulk, stop, tail_w, off_w;
  logic [ChunkBits-1:0] chunk_e, cnt, chunk_open;
  logic [2:0]           flags_e;
  logic [LenBits:0]     end_sum;
  logic [LenBits-4:0]   whole, idx, cnt_full;
  logic [3:0]           span, span_m1, tail_n;
  logic                 active, at_end, ex, rd, is_byte, do_exit, accept;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && !q_full_i;

  always_comb begin
    if (req_i.first_byte) begin
      done_e  = '0;
      len_e   = req_i.total_bits;
      chunk_e = '0;
      flags_e = {req_i.capture, req_i.exit_shift, req_i.req_type};
    end else begin
      done_e  = bits_done_q;
      len_e   = req_len_q;
      chunk_e = chunk_left_q;
      flags_e = flags_q;
    end

    active  = done_e < len_e;
    end_sum = {1'b0, done_e} + (LenBits+1)'(8);
    end_v   = (end_sum > {1'b0, len_e}) ? len_e : end_sum[LenBits-1:0];
    span_w  = end_v - done_e;
    span    = span_w[3:0];
    span_m1 = span - 4'd1;
    at_end  = (end_v == len_e);

    ex       = flags_e[1];
    rd       = flags_e[2];
    bulk     = len_e - LenBits'(ex);
    whole    = bulk[LenBits-1:3];
    idx      = done_e[LenBits-1:3];
    is_byte  = idx < whole;
    cnt_full = whole - idx;
    cnt      = (cnt_full > (LenBits-3)'(MaxChunk)) ? ChunkBits'(MaxChunk)
                                                   : cnt_full[ChunkBits-1:0];
    stop     = (end_v < bulk) ? end_v : bulk;
    tail_w   = stop - done_e;
    tail_n   = (stop > done_e) ? tail_w[3:0] : 4'd0;
    do_exit  = ex && at_end;
    off_w    = len_e - done_e - LenBits'(1);

    q_desc_o          = '0;
    q_desc_o.data     = req_i.data_byte;
    q_desc_o.rd       = rd;
    q_desc_o.last_req = at_end;
    q_desc_o.hdr      = HdrShift | (rd ? CmdRead : 8'h00) | 8'(cnt);
    chunk_open        = chunk_e;

    if (flags_e[0]) begin
      q_desc_o.kind    = DESC_TMS;
      q_desc_o.npairs  = span;
      q_desc_o.extra   = at_end ? 2'd1 : 2'd0;
      q_desc_o.xbit    = req_i.data_byte[span_m1[2:0]];
      q_desc_o.n_total = {span, 1'b0} + 5'(q_desc_o.extra);
    end else if (is_byte) begin
      q_desc_o.kind    = DESC_BYTE;
      q_desc_o.hdr_en  = (chunk_e == '0);
      q_desc_o.n_total = q_desc_o.hdr_en ? 5'd2 : 5'd1;
      if (chunk_e == '0) chunk_open = cnt;
    end else begin
      q_desc_o.kind    = DESC_TAIL;
      q_desc_o.npairs  = tail_n;
      q_desc_o.extra   = do_exit ? 2'd3 : 2'd0;
      q_desc_o.xbit    = req_i.data_byte[off_w[2:0]];
      q_desc_o.n_total = {tail_n, 1'b0} + 5'(q_desc_o.extra);
    end

    q_push_o = accept && active;

    bits_done_d  = bits_done_q;
    req_len_d    = req_len_q;
    chunk_left_d = chunk_left_q;
    flags_d      = flags_q;
    if (accept) begin
      req_len_d    = len_e;
      flags_d      = flags_e;
      bits_done_d  = done_e;
      chunk_left_d = chunk_e;
      if (active) begin
        bits_done_d = end_v;
        if (!flags_e[0] && is_byte) begin
          chunk_left_d = (chunk_open != '0) ? chunk_open - ChunkBits'(1) : chunk_open;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_done_q  <= '0;
      req_len_q    <= '0;
      chunk_left_q <= '0;
      flags_q      <= '0;
    end else begin
      bits_done_q  <= bits_done_d;
      req_len_q    <= req_len_d;
      chunk_left_q <= chunk_left_d;
      flags_q      <= flags_d;
    end
  end

endmodule

// ----- rtl/jsce_queue.sv -----
// Short descriptor queue between the front and back ends.
// Depends on jsce_pkg for the descriptor type and the depth.
module jsce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsce_pkg::desc_t push_desc_i,
  output logic            full_o,
  output logic            valid_o,
  output jsce_pkg::desc_t head_o,
  input  logic            pop_i
);
  import jsce_pkg::*;

  desc_t               slot_q [QDepth];
  logic [QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrBits:0]   count_q;
  logic                do_pop;

  assign full_o  = (count_q == (QPtrBits+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrBits'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrBits'(1);
      if (push_i && !do_pop)      count_q <= count_q + (QPtrBits+1)'(1);
      else if (do_pop && !push_i) count_q <= count_q - (QPtrBits+1)'(1);
    end
  end

endmodule

// ----- rtl/jsce_back.sv -----
// Back end: expands one descriptor into its command bytes, one per cycle while cmd_o is not stalled.
// Depends on jsce_pkg and jsce_out_if.
module jsce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  jsce_pkg::desc_t q_desc_i,
  output logic            q_pop_o,
  jsce_out_if.source      cmd_o
);
  import jsce_pkg::*;

  logic [4:0] pos_q, pos_d, pairs2, ext;
  logic [7:0] cmd_byte;
  logic       out_v_q, out_v_d, last_pos, load, bitv, tck;
  logic [7:0] cmd_q;
  logic       last_item_q, last_req_q;

  always_comb begin
    pairs2   = {q_desc_i.npairs, 1'b0};
    ext      = pos_q - pairs2;
    bitv     = q_desc_i.data[pos_q[3:1]];
    tck      = pos_q[0];
    last_pos = (pos_q == q_desc_i.n_total - 5'd1);
    load     = q_valid_i && (!out_v_q || cmd_o.ready);

    unique case (q_desc_i.kind)
      DESC_BYTE: cmd_byte = (q_desc_i.hdr_en && pos_q == 5'd0) ? q_desc_i.hdr
                                                               : q_desc_i.data;
      DESC_TMS:  cmd_byte = (pos_q < pairs2) ? bang(bitv, 1'b0, tck, 1'b0)
                                             : bang(q_desc_i.xbit, 1'b0, 1'b0, 1'b0);
      DESC_TAIL: cmd_byte = (pos_q < pairs2) ? bang(1'b0, bitv, tck, tck && q_desc_i.rd)
                                             : bang(1'b1, q_desc_i.xbit, ext[1:0] == 2'd1,
                                                    ext[1:0] == 2'd1 && q_desc_i.rd);
      default:   cmd_byte = q_desc_i.data;
    endcase

    q_pop_o = load && last_pos;
    pos_d   = pos_q;
    if (load) pos_d = last_pos ? 5'd0 : pos_q + 5'd1;
    out_v_d = load ? 1'b1 : (cmd_o.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q       <= cmd_byte;
      last_item_q <= last_pos;
      last_req_q  <= last_pos && q_desc_i.last_req;
    end
  end

  assign cmd_o.valid           = out_v_q;
  assign cmd_o.command_byte    = cmd_q;
  assign cmd_o.last_of_item    = last_item_q;
  assign cmd_o.last_of_request = last_req_q;

endmodule

// ----- rtl/jtag_scan_command_encoder_core.sv -----
// Top level of the JTAG scan command encoder: front end, queue and back end.
// Depends on jsce_pkg, jsce_in_if, jsce_out_if, jsce_front, jsce_queue, jsce_back.
//
//   Channel  Direction  Moves one item of
//   req_i    in         request data byte with its request fields
//   cmd_o    out        adapter command byte with end-of-item/request marks
//
// An accepted byte is classified in the cycle it is taken and, if it yields
// commands, queued as one descriptor; the back end then sends one command byte
// per cycle while cmd_o is not stalled, so a byte yields 1 to 17 command bytes
// (1 or 2 for a whole scan byte, 2 per bit-bang bit plus up to 3 closing commands).
// The two-entry queue lets request bytes be taken while commands stall.
// Reset is asynchronous and active low; it clears request tracking and the queue.
module jtag_scan_command_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsce_in_if.sink    req_i,
  jsce_out_if.source cmd_o
);
  import jsce_pkg::*;

  // Descriptor traffic between the stages.
  desc_t push_desc, head_desc;
  logic  push, q_full, q_valid, q_pop;

  // The front end owns the request state: bits consumed, latched length,
  // open chunk count and the mode flags captured on the first byte.
  jsce_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_push_o (push),
    .q_desc_o (push_desc)
  );

  // Bytes that produce no commands (past the end, or a zero-length request)
  // are accepted but never reach the queue.
  jsce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_desc),
    .pop_i       (q_pop)
  );

  // The back end walks the descriptor and pops it with its final command.
  jsce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_desc_i  (head_desc),
    .q_pop_o   (q_pop),
    .cmd_o     (cmd_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  a_head_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> head_desc.n_total != 5'd0)
    else $error("queued descriptor carries no commands");

  a_req_end_is_item_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid && cmd_o.last_of_request |-> cmd_o.last_of_item)
    else $error("request end marked on a command that does not end its item");

  a_pop_only_with_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
